// ----- design/puct_child_select_defines.svh -----
// Assertion macros for the PUCT child selector.
`ifndef PUCT_CHILD_SELECT_DEFINES_SVH
`define PUCT_CHILD_SELECT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PCS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/pcs_pkg.sv -----
`timescale 1ns / 1ps
package pcs_pkg;
  localparam int MAX_CHILDREN = 1024;
  localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
  localparam int IDX_W = 10;
  localparam int SCORE_W = 48;
  localparam int EW_W = 24;
  localparam int PRIOR_W = 17;
  localparam logic [EW_W-1:0] EW_RESET = 24'd6554;
  localparam logic [SCORE_W-1:0] UCB_MAX = {SCORE_W{1'b1}};

  // One classified child as it travels from the front to the back.
  typedef struct packed {
    logic [31:0]        parent;
    logic [31:0]        child;
    logic [SCORE_W-1:0] score;
    logic [PRIOR_W-1:0] prior;
    logic               last;
    logic               counted;
    logic [IDX_W-1:0]   index;
  } pcs_job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ITER, ST_ESTEP, ST_CMP
  } pcs_state_t;
endpackage

// ----- design/puct_child_select.sv -----
`timescale 1ns / 1ps
// The result beat follows the last child in the cycle after its comparison.
// The back takes a new child only once it is done with the last one; a
// counted child runs the shared bit-serial divide pass (64 steps) and the
// square root pass (32 steps), while an uncounted child skips both.
// Reset: synchronous active-low rst_n clears the queue, counters and best.
`include "puct_child_select_defines.svh"
module puct_child_select (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pcs_pkg::EW_W-1:0]    cfg_explore_weight,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 in_parent_visits,
  input  logic [31:0]                 in_child_visits,
  input  logic [pcs_pkg::SCORE_W-1:0] in_child_score_total,
  input  logic [pcs_pkg::PRIOR_W-1:0] in_child_prior,
  input  logic                        in_last_child,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pcs_pkg::IDX_W-1:0]   out_best_child
);
  logic [pcs_pkg::EW_W-1:0] ew_r;
  logic q_valid, q_pop;
  pcs_pkg::pcs_job_t q_job;

  always_ff @(posedge clk) begin
    if (!rst_n) ew_r <= pcs_pkg::EW_RESET;
    else if (cfg_we) ew_r <= cfg_explore_weight;
  end

  pcs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_parent_visits, .in_child_visits,
    .in_child_score_total, .in_child_prior, .in_last_child,
    .q_valid, .q_job, .q_pop
  );

  pcs_back u_back (
    .clk, .rst_n, .explore_weight(ew_r), .q_valid, .q_job, .q_pop,
    .out_valid, .out_stall, .out_best_child
  );

  `PCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `PCS_ASSERT_IMP(a_pop_valid, clk, rst_n, q_pop, q_valid)
  `PCS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_best_child))
endmodule

// ----- design/pcs_front.sv -----
`timescale 1ns / 1ps
// Accepts children, numbers them and pushes them into a two-entry queue.
module pcs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                in_parent_visits,
  input  logic [31:0]                in_child_visits,
  input  logic [pcs_pkg::SCORE_W-1:0] in_child_score_total,
  input  logic [pcs_pkg::PRIOR_W-1:0] in_child_prior,
  input  logic                       in_last_child,
  output logic                       q_valid,
  output pcs_pkg::pcs_job_t          q_job,
  input  logic                       q_pop
);
  pcs_pkg::pcs_job_t mem_r [2];
  logic rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic [pcs_pkg::CNT_W-1:0] ctr_r;
  logic push;
  pcs_pkg::pcs_job_t job;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_job = mem_r[rd_ptr_r];

  always_comb begin
    job.parent  = in_parent_visits;
    job.child   = in_child_visits;
    job.score   = in_child_score_total;
    job.prior   = in_child_prior;
    job.last    = in_last_child;
    job.counted = (ctr_r < pcs_pkg::CNT_W'(pcs_pkg::MAX_CHILDREN));
    job.index   = ctr_r[pcs_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= job;
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      ctr_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
      if (push) begin
        if (in_last_child) ctr_r <= '0;
        else if (job.counted) ctr_r <= ctr_r + 1'b1;
      end
    end
  end
endmodule

// ----- design/pcs_back.sv -----
`timescale 1ns / 1ps
// Works out one child's score with a shared iteration counter: a restoring
// divider for the mean, a divider for the root argument, then a digit-pair
// square root, and keeps the running best.
module pcs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pcs_pkg::EW_W-1:0]    explore_weight,
  input  logic                       q_valid,
  input  pcs_pkg::pcs_job_t          q_job,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pcs_pkg::IDX_W-1:0]  out_best_child
);
  pcs_pkg::pcs_state_t st_r, st_nxt;
  pcs_pkg::pcs_job_t job_r;
  logic [5:0] it_r;
  logic [1:0] ph_r; // 0 both divides, 2 square root
  logic [63:0] qd_r;       // mean dividend shifting to quotient
  logic [32:0] qrem_r;
  logic [63:0] ud_r;       // parent<<32 dividend
  logic [33:0] urem_r;
  logic [63:0] sx_r;       // square root radicand
  logic [33:0] srem_r;
  logic [31:0] sroot_r;
  logic [24:0] cp_r;
  logic [63:0] e_r;
  logic [pcs_pkg::SCORE_W-1:0] best_score_r, ucb;
  logic [pcs_pkg::IDX_W-1:0] best_idx_r;
  logic have_r;
  logic res_r;
  logic [pcs_pkg::IDX_W-1:0] res_idx_r;
  logic [32:0] qtry;
  logic [33:0] utry, strial, stry;
  logic [48:0] sum;
  logic [32:0] dsr;

  assign q_pop = (st_r == pcs_pkg::ST_IDLE) && q_valid && !(res_r && q_job.last);
  assign out_valid = res_r;
  assign out_best_child = res_idx_r;
  assign dsr = {1'b0, job_r.child} + 33'd1;
  assign qtry = {qrem_r[31:0], qd_r[63]};
  assign utry = {urem_r[32:0], ud_r[63]};
  assign strial = {srem_r[31:0], sx_r[63:62]};
  assign stry = {sroot_r, 2'b01};
  assign sum = {1'b0, qd_r[47:0]} + {1'b0, e_r[63:16]};
  assign ucb = (sum[48] || e_r[63:16] > 48'(pcs_pkg::UCB_MAX)) ? pcs_pkg::UCB_MAX : sum[47:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pcs_pkg::ST_IDLE:  if (q_pop) st_nxt = pcs_pkg::ST_MUL;
      pcs_pkg::ST_MUL:   st_nxt = job_r.counted ? pcs_pkg::ST_ITER : pcs_pkg::ST_CMP;
      pcs_pkg::ST_ITER:  if (ph_r == 2'd2 && it_r == 6'd31) st_nxt = pcs_pkg::ST_ESTEP;
      pcs_pkg::ST_ESTEP: st_nxt = pcs_pkg::ST_CMP;
      pcs_pkg::ST_CMP:   st_nxt = pcs_pkg::ST_IDLE;
      default:           st_nxt = pcs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pcs_pkg::ST_IDLE;
      res_r <= 1'b0;
      have_r <= 1'b0;
      best_score_r <= '0;
      best_idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (res_r && !out_stall) res_r <= 1'b0;
      if (st_r == pcs_pkg::ST_CMP) begin
        if (job_r.counted && (!have_r || ucb > best_score_r)) begin
          best_score_r <= ucb;
          best_idx_r <= job_r.index;
          have_r <= 1'b1;
        end
        if (job_r.last) begin
          res_r <= 1'b1;
          res_idx_r <= (job_r.counted && (!have_r || ucb > best_score_r))
                       ? job_r.index : best_idx_r;
          have_r <= 1'b0;
          best_score_r <= '0;
          best_idx_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      pcs_pkg::ST_IDLE: begin
        job_r <= q_job;
        it_r <= '0;
        ph_r <= 2'd0;
      end
      pcs_pkg::ST_MUL: begin
        cp_r <= 25'(({17'd0, explore_weight} * {24'd0, job_r.prior}) >> 16);
        qd_r <= {16'd0, job_r.score};
        qrem_r <= '0;
        ud_r <= {job_r.parent, 32'd0};
        urem_r <= '0;
        srem_r <= '0;
        sroot_r <= '0;
      end
      pcs_pkg::ST_ITER: begin
        // The counter wraps from 63 to 0 on its own at the end of the divide pass.
        it_r <= it_r + 6'd1;
        if (ph_r == 2'd0) begin
          // Two dividers share the pass; the mean only needs 48 steps, but
          // 64 cover both with the root divide.
          if (qtry >= {1'b0, job_r.child}) begin
            qrem_r <= qtry - {1'b0, job_r.child};
            qd_r <= {qd_r[62:0], 1'b1};
          end else begin
            qrem_r <= qtry;
            qd_r <= {qd_r[62:0], 1'b0};
          end
          if (utry >= {1'b0, dsr}) begin
            urem_r <= utry - {1'b0, dsr};
            ud_r <= {ud_r[62:0], 1'b1};
          end else begin
            urem_r <= utry;
            ud_r <= {ud_r[62:0], 1'b0};
          end
          if (it_r == 6'd63) ph_r <= 2'd2;
          if (it_r == 6'd63) sx_r <= {ud_r[62:0], (utry >= {1'b0, dsr})};
        end else begin
          if (strial >= stry) begin
            srem_r <= strial - stry;
            sroot_r <= {sroot_r[30:0], 1'b1};
          end else begin
            srem_r <= strial;
            sroot_r <= {sroot_r[30:0], 1'b0};
          end
          sx_r <= {sx_r[61:0], 2'b00};
        end
      end
      pcs_pkg::ST_ESTEP: begin
        if (job_r.child == 32'd0) qd_r <= '0;
        e_r <= 64'(cp_r) * ((job_r.parent == 32'd0) ? 64'd65536 : {32'd0, sroot_r});
      end
      default: ;
    endcase
  end
endmodule
